FILE: rtl/png_scanline_unfilter_assert.svh
// Assertion macros shared by the scanline unfilter RTL
`ifndef PNG_SCANLINE_UNFILTER_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_ASSERT_SVH

`ifndef SYNTHESIS

// Property checked on every clock edge outside reset
`define PSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication form: when ante holds, cons must follow
`define PSU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) else $error(msg);

`else

`define PSU_ASSERT(lbl, prop, msg)
`define PSU_ASSERT_IMPL(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/psu_pkg.sv
// Shared constants, codes and the work item type of the scanline unfilter
package psu_pkg;

  localparam int PSU_MAX_WIDTH = 4096;
  localparam int PSU_MAX_BPP   = 4;

  localparam int COL_W       = 15;
  localparam int ROW_W       = 16;
  localparam int WIDTH_W     = 13;
  localparam int BPP_W       = 3;
  localparam int TAP_W       = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 4;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_BPP    = 2'd2
  } cfg_reg_t;

  // filter type codes
  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  // one classified byte handed from the front to the back
  typedef struct packed {
    logic [7:0]       data;
    logic [2:0]       filter;
    logic [COL_W-1:0] col;       // byte index within the row
    logic             addr_ok;   // index lies inside the line store
    logic             has_up;    // a row above exists
    logic             first;     // first byte of the row
    logic [TAP_W-1:0] tap;       // bytes per pixel minus one
    logic             row_end;
    logic             image_end;
    logic             bad;
  } work_t;

endpackage

FILE: rtl/psu_front.sv
// Front end: config registers, row/column tracking and byte classification
`include "png_scanline_unfilter_assert.svh"

module psu_front #(
  parameter int MAX_WIDTH = psu_pkg::PSU_MAX_WIDTH,
  parameter int MAX_BPP   = psu_pkg::PSU_MAX_BPP
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             stream_valid,
  output logic                             stream_ready,
  input  logic [7:0]                       stream_byte,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [psu_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [psu_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             push,
  output psu_pkg::work_t                   push_item,
  input  logic                             queue_full
);
  import psu_pkg::*;

  localparam int LINE_DEPTH = MAX_WIDTH * MAX_BPP;

  logic [WIDTH_W-1:0] image_width;
  logic [ROW_W-1:0]   image_height;
  logic [BPP_W-1:0]   bytes_per_pixel;

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row_count;
  logic [2:0]       row_filter;
  logic             dropping;

  logic [WIDTH_W-1:0] width_c;
  logic [ROW_W-1:0]   height_c;
  logic [BPP_W-1:0]   bpp_c;
  logic [COL_W:0]     row_len;
  logic [COL_W-1:0]   x;
  logic               take;
  logic               bad_byte;
  logic               last_row;
  logic               row_done;
  logic               img_done;

  assign stream_ready = !queue_full;
  assign cfg_ready    = 1'b1;
  assign take         = stream_valid && stream_ready;
  assign bad_byte     = stream_byte > 8'(FILT_PAETH);

  always_comb begin
    if (image_width == '0) begin
      width_c = WIDTH_W'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      width_c = WIDTH_W'(MAX_WIDTH);
    end else begin
      width_c = image_width;
    end
    if (bytes_per_pixel < BPP_W'(3)) begin
      bpp_c = BPP_W'(3);
    end else if (32'(bytes_per_pixel) > MAX_BPP) begin
      bpp_c = BPP_W'(MAX_BPP);
    end else begin
      bpp_c = bytes_per_pixel;
    end
    height_c = (image_height == '0) ? ROW_W'(1) : image_height;
  end

  assign row_len  = (COL_W+1)'(width_c) * (COL_W+1)'(bpp_c);
  assign x        = col - COL_W'(1);
  assign row_done = ({1'b0, x} + (COL_W+1)'(1)) >= row_len;
  assign last_row = ({1'b0, row_count} + (ROW_W+1)'(1)) >= {1'b0, height_c};
  assign img_done = row_done && last_row;

  always_comb begin
    push      = 1'b0;
    push_item = '0;
    if (col == '0) begin
      push                = take && !dropping && bad_byte;
      push_item.bad       = 1'b1;
    end else begin
      push                = take && !dropping;
      push_item.data      = stream_byte;
      push_item.filter    = row_filter;
      push_item.col       = x;
      push_item.addr_ok   = 32'(x) < LINE_DEPTH;
      // the row of this byte is the last one when the image closes here
      push_item.has_up    = img_done ? (height_c != ROW_W'(1)) : (row_count != '0);
      push_item.first     = (x == '0);
      push_item.tap       = TAP_W'(bpp_c - BPP_W'(1));
      push_item.row_end   = row_done;
      push_item.image_end = img_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= WIDTH_W'(1);
      image_height    <= ROW_W'(1);
      bytes_per_pixel <= BPP_W'(4);
      col             <= '0;
      row_count       <= '0;
      row_filter      <= FILT_NONE;
      dropping        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_WIDTH:  image_width     <= cfg_data[WIDTH_W-1:0];
          CFG_HEIGHT: image_height    <= cfg_data[ROW_W-1:0];
          CFG_BPP:    bytes_per_pixel <= cfg_data[BPP_W-1:0];
          default: ;
        endcase
      end
      if (take) begin
        if (col == '0) begin
          col <= COL_W'(1);
          if (!dropping) begin
            row_filter <= stream_byte[2:0];
            if (bad_byte) begin
              dropping <= 1'b1;
            end
          end
        end else begin
          col <= row_done ? '0 : col + COL_W'(1);
          if (img_done) begin
            row_count <= '0;
          end else if (row_done) begin
            row_count <= row_count + ROW_W'(1);
          end
          if (dropping && img_done) begin
            dropping <= 1'b0;
          end
        end
      end
    end
  end

  `PSU_ASSERT_IMPL(a_drop_after_bad, take && col == '0 && !dropping && bad_byte, ##1 dropping, "bad filter did not start dropping")
  `PSU_ASSERT_IMPL(a_push_image_end, push && push_item.image_end, push_item.row_end, "image end without row end")

endmodule

FILE: rtl/psu_queue.sv
// Short work queue between the front end and the back end
`include "png_scanline_unfilter_assert.svh"

module psu_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  psu_pkg::work_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output psu_pkg::work_t pop_item
);
  import psu_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  work_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full      = count == (PTR_W+1)'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign pop_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (PTR_W+1)'(1);
        2'b01:   count <= count - (PTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

  `PSU_ASSERT(a_count_bound, count <= (PTR_W+1)'(QUEUE_DEPTH), "queue count overflow")
  `PSU_ASSERT_IMPL(a_pop_nonempty, pop, not_empty, "pop from empty queue")

endmodule

FILE: rtl/psu_back.sv
// Back end: line store read, reconstruction and output register
`include "png_scanline_unfilter_assert.svh"

module psu_back #(
  parameter int MAX_WIDTH = psu_pkg::PSU_MAX_WIDTH,
  parameter int MAX_BPP   = psu_pkg::PSU_MAX_BPP
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_pop,
  input  psu_pkg::work_t q_item,
  output logic           sample_valid,
  input  logic           sample_ready,
  output logic [7:0]     sample_byte,
  output logic           row_end,
  output logic           image_end,
  output logic           bad_filter
);
  import psu_pkg::*;

  localparam int LINE_DEPTH = MAX_WIDTH * MAX_BPP;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);

  function automatic logic [9:0] abs10(input logic signed [9:0] v);
    return (v < 0) ? 10'(-v) : 10'(v);
  endfunction

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [9:0] d_bc;
    logic signed [9:0] d_ac;
    logic [9:0]        pa;
    logic [9:0]        pb;
    logic [9:0]        pc;
    d_bc = $signed({2'b00, b}) - $signed({2'b00, c});
    d_ac = $signed({2'b00, a}) - $signed({2'b00, c});
    pa   = abs10(d_bc);
    pb   = abs10(d_ac);
    pc   = abs10(d_bc + d_ac);
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end
    return c;
  endfunction

  logic [7:0] line_mem [LINE_DEPTH];
  logic [7:0] up_q;

  work_t stage;
  logic  stage_valid;
  logic  advance;

  logic [7:0] left_bytes    [MAX_BPP];
  logic [7:0] up_left_bytes [MAX_BPP];

  logic [7:0] a;
  logic [7:0] b;
  logic [7:0] c;
  logic [7:0] pred;
  logic [8:0] avg_sum;
  logic [7:0] result;

  assign advance = stage_valid && (!sample_valid || sample_ready);
  assign q_pop   = q_valid && (!stage_valid || advance);

  // line store: read at pop, written when the byte leaves the stage
  always_ff @(posedge clk) begin
    if (q_pop) begin
      up_q <= line_mem[ADDR_W'(q_item.col)];
    end
    if (advance && !stage.bad && stage.addr_ok) begin
      line_mem[ADDR_W'(stage.col)] <= result;
    end
  end

  always_comb begin
    a       = stage.first ? 8'd0 : left_bytes[stage.tap];
    b       = (stage.has_up && stage.addr_ok) ? up_q : 8'd0;
    c       = (stage.first || !stage.has_up) ? 8'd0 : up_left_bytes[stage.tap];
    avg_sum = {1'b0, a} + {1'b0, b};
    case (stage.filter)
      FILT_NONE:  pred = 8'd0;
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: pred = paeth(a, b, c);
      default:    pred = 8'd0;
    endcase
    result = stage.data + pred;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      stage <= q_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= 1'b0;
      sample_valid <= 1'b0;
      for (int i = 0; i < MAX_BPP; i++) begin
        left_bytes[i]    <= 8'd0;
        up_left_bytes[i] <= 8'd0;
      end
    end else begin
      if (q_pop) begin
        stage_valid <= 1'b1;
      end else if (advance) begin
        stage_valid <= 1'b0;
      end
      if (advance) begin
        sample_valid <= 1'b1;
      end else if (sample_ready) begin
        sample_valid <= 1'b0;
      end
      if (advance && !stage.bad) begin
        // a new row starts from cleared neighbors
        for (int i = 1; i < MAX_BPP; i++) begin
          left_bytes[i]    <= stage.first ? 8'd0 : left_bytes[i-1];
          up_left_bytes[i] <= stage.first ? 8'd0 : up_left_bytes[i-1];
        end
        left_bytes[0]    <= result;
        up_left_bytes[0] <= b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sample_byte <= stage.bad ? 8'd0 : result;
      row_end     <= stage.row_end;
      image_end   <= stage.image_end;
      bad_filter  <= stage.bad;
    end
  end

  `PSU_ASSERT_IMPL(a_bad_clean, sample_valid && bad_filter, sample_byte == 8'd0 && !row_end && !image_end, "error request carries data")
  `PSU_ASSERT_IMPL(a_img_row_end, sample_valid && image_end, row_end, "image end without row end")

endmodule

FILE: rtl/png_scanline_unfilter.sv
// PNG scanline unfilter, top level.
// Takes inflated image data one byte per request and returns one reconstructed
// sample per filtered byte; valid filter-type bytes and the bytes of a dropped
// image give no result; a bad filter-type byte gives one bad_filter sample.
// Sustained rate is one byte per clock while sample_ready holds. The front
// end classifies each byte into a four-entry queue, the back end reads the line
// store at the queue head, then reconstructs and registers the result. The loop
// that sets the rate is the line store's single read and write port together
// with the left-neighbor chain, which reaches back bytes_per_pixel results. The
// line store has no clearing pass; it is ready right after reset. Write
// configuration only while no request is in flight.
module png_scanline_unfilter #(
  parameter int MAX_WIDTH = psu_pkg::PSU_MAX_WIDTH,
  parameter int MAX_BPP   = psu_pkg::PSU_MAX_BPP
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            stream_valid,
  output logic                            stream_ready,
  input  logic [7:0]                      stream_byte,
  output logic                            sample_valid,
  input  logic                            sample_ready,
  output logic [7:0]                      sample_byte,
  output logic                            row_end,
  output logic                            image_end,
  output logic                            bad_filter,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [psu_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [psu_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import psu_pkg::*;

  logic  push;
  work_t push_item;
  logic  queue_full;
  logic  q_pop;
  logic  q_valid;
  work_t q_item;

  psu_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_BPP   (MAX_BPP)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .stream_valid (stream_valid),
    .stream_ready (stream_ready),
    .stream_byte  (stream_byte),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .push_item    (push_item),
    .queue_full   (queue_full)
  );

  psu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_item  (q_item)
  );

  psu_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_BPP   (MAX_BPP)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_item       (q_item),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_byte  (sample_byte),
    .row_end      (row_end),
    .image_end    (image_end),
    .bad_filter   (bad_filter)
  );

endmodule
